### hw/rtl/dfmt_pkg.sv
// shared types and constants for the decimal field formatter
// no dependencies; imported by every dfmt module
`timescale 1ns / 1ps
`default_nettype none
package dfmt_pkg;
	localparam int MAX_WIDTH  = 10;
	localparam int NUM_DIGITS = 5;                      // digits of a 16-bit magnitude
	localparam int WW         = $clog2(MAX_WIDTH + 1);  // clamped width / position bits
	localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	// x / 10 == (x * RECIP10) >> RECIP_SHIFT for every 16-bit x
	localparam logic [16:0] RECIP10     = 17'h0CCCD;
	localparam int          RECIP_SHIFT = 19;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;

	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

	typedef struct packed {
		logic          sgn;
		logic          neg;
		logic [WW-1:0] w;
		logic [7:0]    fill;
		logic          port;
		digits_t       digits;  // index 0 is the least significant digit
	} desc_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SIGN,
		B_DIGIT
	} back_state_t;
endpackage
`default_nettype wire

### hw/rtl/decimal_field_formatter_core.sv
// top level of the decimal field formatter: front end, descriptor queue, back end
// depends on dfmt_pkg, dfmt_front, dfmt_queue, dfmt_back
`timescale 1ns / 1ps
`default_nettype none
// An item is taken when start is high and busy is low. The front end accepts it,
// converts the magnitude one divide-by-ten step a cycle through a shared reciprocal
// multiplier and then hands the digits to a two-entry queue; busy stays high until
// that hand-off, so no new item is taken before it, and the hand-off waits only while
// the queue is full.
// The back end emits one character per cycle (sign, then width digits, the last marked)
// and passes through an idle state to fetch each entry from the queue before its field.
// Each character appears for exactly one cycle with strobe high; the receiver cannot
// hold results off. An unsigned item of width zero produces no characters.
module decimal_field_formatter_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [15:0] value,
	input  wire         is_signed,
	input  wire  [3:0]  width,
	input  wire  [7:0]  fill_char,
	input  wire         port,
	output logic        strobe,
	output logic [7:0]  char_out,
	output logic        port_out,
	output logic        last
);
	import dfmt_pkg::*;

	logic  push, full, pop, empty;
	desc_t wr_desc, rd_desc;

	dfmt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.is_signed (is_signed),
		.width     (width),
		.fill_char (fill_char),
		.port      (port),
		.push      (push),
		.desc      (wr_desc),
		.full      (full)
	);

	dfmt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_desc (wr_desc),
		.full    (full),
		.pop     (pop),
		.rd_desc (rd_desc),
		.empty   (empty)
	);

	dfmt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.rd_desc  (rd_desc),
		.pop      (pop),
		.strobe   (strobe),
		.char_out (char_out),
		.port_out (port_out),
		.last     (last)
	);
endmodule
`default_nettype wire

### hw/rtl/dfmt_front.sv
// front end: accepts an item, clamps width, converts magnitude to decimal digits
// one digit per cycle; depends on dfmt_pkg
`timescale 1ns / 1ps
`default_nettype none
module dfmt_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire  [15:0]           value,
	input  wire                   is_signed,
	input  wire  [3:0]            width,
	input  wire  [7:0]            fill_char,
	input  wire                   port,
	output logic                  push,
	output dfmt_pkg::desc_t       desc,
	input  wire                   full
);
	import dfmt_pkg::*;

	front_state_t state_q, state_d;
	logic [DIG_IDX_W-1:0] cnt_q;
	logic [15:0] mag_q;
	desc_t desc_q;

	logic [32:0] prod;
	logic [13:0] quot;
	logic [15:0] quot10;
	logic [3:0]  dig;
	logic        accept;
	logic [15:0] mag_in;
	logic [WW-1:0] w_clamped;

	assign accept = start && (state_q == F_IDLE);
	assign mag_in = (is_signed && value[15]) ? 16'(~value + 16'd1) : value;
	assign w_clamped = (int'(width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width);

	// divide by ten through the reciprocal, remainder by subtraction
	assign prod   = 33'(mag_q) * 33'(RECIP10);
	assign quot   = prod[RECIP_SHIFT+13:RECIP_SHIFT];
	assign quot10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
	assign dig    = 4'(mag_q - quot10);

	always_comb begin
		state_d = state_q;
		busy    = (state_q != F_IDLE);
		push    = 1'b0;
		case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_CONV;
			end
			F_CONV: begin
				if (cnt_q == DIG_IDX_W'(NUM_DIGITS - 1)) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign desc = desc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= '0;
			else if (state_q == F_CONV) cnt_q <= cnt_q + DIG_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q       <= mag_in;
			desc_q.sgn  <= is_signed;
			desc_q.neg  <= is_signed && value[15];
			desc_q.w    <= w_clamped;
			desc_q.fill <= fill_char;
			desc_q.port <= port;
		end else if (state_q == F_CONV) begin
			mag_q         <= 16'(quot);
			// digits shift in from the top, so the first one ends at index 0
			desc_q.digits <= {dig, desc_q.digits[NUM_DIGITS-1:1]};
		end
	end
endmodule
`default_nettype wire

### hw/rtl/dfmt_queue.sv
// short descriptor queue between the front and back ends
// depends on dfmt_pkg
`timescale 1ns / 1ps
`default_nettype none
module dfmt_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  dfmt_pkg::desc_t  wr_desc,
	output logic             full,
	input  wire              pop,
	output dfmt_pkg::desc_t  rd_desc,
	output logic             empty
);
	import dfmt_pkg::*;

	desc_t entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_desc = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= wr_desc;
	end
endmodule
`default_nettype wire

### hw/rtl/dfmt_back.sv
// back end: walks one descriptor and emits its characters one per cycle
// depends on dfmt_pkg
`timescale 1ns / 1ps
`default_nettype none
module dfmt_back (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              empty,
	input  dfmt_pkg::desc_t  rd_desc,
	output logic             pop,
	output logic             strobe,
	output logic [7:0]       char_out,
	output logic             port_out,
	output logic             last
);
	import dfmt_pkg::*;

	back_state_t state_q, state_d;
	desc_t cur_q;
	logic [WW-1:0] pos_q;
	logic lead_q;

	logic          emit;
	logic [7:0]    ch;
	logic          is_last;
	logic [3:0]    dig;
	logic [WW-1:0] pos_d;
	logic          lead_d;

	// positions above the fifth digit are always zero
	always_comb begin
		if (int'(pos_q) < NUM_DIGITS) dig = cur_q.digits[pos_q[DIG_IDX_W-1:0]];
		else dig = 4'd0;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		emit    = 1'b0;
		ch      = CH_ZERO;
		is_last = 1'b0;
		pos_d   = pos_q;
		lead_d  = lead_q;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop    = 1'b1;
					pos_d  = rd_desc.w - WW'(1);
					lead_d = 1'b1;
					if (rd_desc.sgn) state_d = B_SIGN;
					else if (rd_desc.w != '0) state_d = B_DIGIT;
				end
			end
			B_SIGN: begin
				emit    = 1'b1;
				ch      = cur_q.neg ? CH_MINUS : CH_PLUS;
				is_last = (cur_q.w == '0);
				state_d = (cur_q.w == '0) ? B_IDLE : B_DIGIT;
			end
			B_DIGIT: begin
				emit    = 1'b1;
				is_last = (pos_q == '0);
				// the final digit is never filled
				if (dig == 4'd0 && lead_q && pos_q != '0) begin
					ch = cur_q.fill;
				end else begin
					ch     = CH_ZERO + 8'(dig);
					lead_d = 1'b0;
				end
				if (pos_q == '0) state_d = B_IDLE;
				else pos_d = pos_q - WW'(1);
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= rd_desc;
		pos_q    <= pos_d;
		lead_q   <= lead_d;
		char_out <= ch;
		port_out <= cur_q.port;
		last     <= is_last;
	end
endmodule
`default_nettype wire

### tb/decimal_field_formatter_core_test.sv
// self-checking testbench for decimal_field_formatter_core: directed and random fields
// depends on dfmt_pkg and the formatter rtl; predicts every character and checks each beat
`timescale 1ns / 1ps
module decimal_field_formatter_core_test;
	import dfmt_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       port;
		logic       last;
	} char_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [15:0] value = '0;
	logic        is_signed = 1'b0;
	logic [3:0]  width = '0;
	logic [7:0]  fill_char = '0;
	logic        port = 1'b0;
	logic        busy;
	logic        strobe;
	logic [7:0]  char_out;
	logic        port_out;
	logic        last;

	char_beat_t pending_chars[$];
	int         mismatch_count = 0;
	int         sender_idle_pct = 0;

	decimal_field_formatter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.is_signed (is_signed),
		.width     (width),
		.fill_char (fill_char),
		.port      (port),
		.strobe    (strobe),
		.char_out  (char_out),
		.port_out  (port_out),
		.last      (last)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// sign first when signed, then exactly w digits with leading zeros but the last swapped for the fill byte
	function automatic void format_field(input logic [15:0] v, input logic sgn,
			input logic [3:0] w_in, input logic [7:0] fill, input logic p);
		int          w;
		int          i;
		int unsigned mag;
		logic [7:0]  digs[MAX_WIDTH];
		bit          leading;
		w = (w_in > MAX_WIDTH) ? MAX_WIDTH : int'(w_in);
		mag = 32'(v);
		if (sgn) begin
			if (v[15])
				mag = 32'h10000 - v;
			pending_chars.push_back('{v[15] ? CH_MINUS : CH_PLUS, p, w == 0});
		end
		for (i = w - 1; i >= 0; i--) begin
			digs[i] = CH_ZERO + 8'(mag % 10);
			mag = mag / 10;
		end
		leading = 1'b1;
		for (i = 0; i + 1 < w; i++) begin
			if (leading && digs[i] == CH_ZERO)
				digs[i] = fill;
			else
				leading = 1'b0;
		end
		for (i = 0; i < w; i++)
			pending_chars.push_back('{digs[i], p, i + 1 == w});
	endfunction

	// one beat on the command side, then a random gap as the idling phase asks
	task automatic send_field(input logic [15:0] v, input logic sgn, input logic [3:0] w,
			input logic [7:0] fill, input logic p);
		int gap;
		@(posedge clk);
		start     <= 1'b1;
		value     <= v;
		is_signed <= sgn;
		width     <= w;
		fill_char <= fill;
		port      <= p;
		do
			@(negedge clk);
		while (busy);
		@(posedge clk);
		format_field(v, sgn, w, fill, p);
		start <= 1'b0;
		gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 14) : 0;
		repeat (gap) @(posedge clk);
	endtask

	// characters are sampled mid-cycle, away from the edge that moves them
	always @(negedge clk) begin
		char_beat_t want;
		if (arst_n && strobe) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h", char_out));
			end else begin
				want = pending_chars.pop_front();
				if (char_out !== want.ch)
					report_mismatch($sformatf("char_out 0x%02h, want 0x%02h",
						char_out, want.ch));
				if (port_out !== want.port)
					report_mismatch($sformatf("port_out %b, want %b", port_out, want.port));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b", last, want.last));
			end
		end
	end

	// bounded wait for the field queue to empty, then let any silent item finish
	task automatic wait_drained(input int settle);
		int waited;
		waited = 0;
		while (pending_chars.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_chars.size() != 0) begin
			report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));
			pending_chars.delete();
		end
		repeat (settle) @(posedge clk);
	endtask

	task automatic send_random_field();
		logic [15:0] v;
		logic [3:0]  w;
		case ($urandom_range(0, 3))
			0: v = 16'($urandom_range(0, 9));
			1: v = 16'($urandom_range(0, 999));
			2: v = $urandom_range(0, 1) ? 16'(32'h8000 + $urandom_range(0, 15))
				: 16'(32'h7FFF - $urandom_range(0, 15));
			default: v = 16'($urandom);
		endcase
		w = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(11, 15))
			: 4'($urandom_range(0, 10));
		send_field(v, 1'($urandom_range(0, 1)), w, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_directed_fields();
		sender_idle_pct = 0;
		send_field(16'd0, 1'b0, 4'd0, 8'h20, 1'b0);       // unsigned, no digits at all
		send_field(16'd7, 1'b1, 4'd0, 8'h20, 1'b1);       // sign alone, marked last
		send_field(16'hFFF9, 1'b1, 4'd0, 8'h2A, 1'b0);
		send_field(16'd0, 1'b0, 4'd1, 8'h20, 1'b1);
		send_field(16'd0, 1'b0, 4'd10, 8'hFF, 1'b0);
		send_field(16'hFFFF, 1'b0, 4'd10, 8'h00, 1'b1);
		send_field(16'hFFFF, 1'b0, 4'd15, 8'h20, 1'b0);   // width clamps to ten
		send_field(16'd42, 1'b0, 4'd11, 8'h2E, 1'b1);
		send_field(16'h8000, 1'b1, 4'd5, 8'h20, 1'b0);    // most negative value
		send_field(16'h8000, 1'b1, 4'd10, 8'h30, 1'b1);
		send_field(16'h7FFF, 1'b1, 4'd5, 8'h20, 1'b0);
		send_field(16'hFFFF, 1'b1, 4'd3, 8'h20, 1'b1);
		send_field(16'd12345, 1'b0, 4'd3, 8'h20, 1'b0);   // high digits dropped
		send_field(16'd1000, 1'b0, 4'd3, 8'h5F, 1'b1);    // kept digits all zero
		send_field(16'd100, 1'b0, 4'd8, 8'h20, 1'b0);
		send_field(16'd9, 1'b1, 4'd4, 8'hA5, 1'b1);
		send_field(16'd65530, 1'b0, 4'd5, 8'h5A, 1'b0);
		send_field(16'd501, 1'b0, 4'd2, 8'h20, 1'b1);
		send_field(16'hFF38, 1'b1, 4'd6, 8'h00, 1'b0);
		send_field(16'd3, 1'b0, 4'd7, 8'hC3, 1'b1);
	endtask

	task automatic test_random_fields(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			// cycle the sender through busy and sparse stretches
			case ((k * 4) / n)
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 45;
				2: sender_idle_pct = 0;
				default: sender_idle_pct = 26;
			endcase
			send_random_field();
		end
	endtask

	task automatic test_drained_pause();
		int k;
		sender_idle_pct = 0;
		for (k = 0; k < 4; k++)
			send_random_field();
		wait_drained(24);
		for (k = 0; k < 4; k++)
			send_random_field();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_fields();
		test_random_fields(72);
		test_drained_pause();
		wait_drained(32);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end
endmodule

### filelist.f
hw/rtl/dfmt_pkg.sv
hw/rtl/dfmt_front.sv
hw/rtl/dfmt_queue.sv
hw/rtl/dfmt_back.sv
hw/rtl/decimal_field_formatter_core.sv
tb/decimal_field_formatter_core_test.sv
